// File: design/plid_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_pkg
// Shared types and constants for the positional list insert/delete block.
// ----------------------------------------------------------------------------
package plid_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned POS_W     = 8;
  localparam int unsigned IDX_W     = 8;
  localparam int unsigned CNT_OUT_W = 5;
  localparam int unsigned STAT_W    = 2;

  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_DELETE = 2'd1,
    CMD_READ   = 2'd2
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INS,
    CELL_DEL,
    CELL_ROT
  } cell_op_e;

  typedef enum logic [1:0] {
    CTRL_IDLE,
    CTRL_HELD,
    CTRL_STREAM
  } ctrl_state_e;

  typedef struct packed {
    cell_op_e                 op;
    logic [IDX_W-1:0]         pos_idx;
    logic [IDX_W-1:0]         tail_idx;
    logic signed [DATA_W-1:0] ins_value;
    logic signed [DATA_W-1:0] head_value;
  } cell_bcast_t;

endpackage

// File: design/plid_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// plid_cell
// One list slot: holds an entry and loads it from its left or right neighbor or from the broadcast.
// ----------------------------------------------------------------------------
module plid_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                clk_i,
  input  plid_pkg::cell_bcast_t               bcast_i,
  input  logic signed [plid_pkg::DATA_W-1:0]  left_i,
  input  logic signed [plid_pkg::DATA_W-1:0]  right_i,
  output logic signed [plid_pkg::DATA_W-1:0]  data_o,
  output logic signed [plid_pkg::DATA_W-1:0]  hit_o
);

  localparam logic [plid_pkg::IDX_W-1:0] MyIdx = plid_pkg::IDX_W'(IDX);

  logic signed [plid_pkg::DATA_W-1:0] data_q;
  logic signed [plid_pkg::DATA_W-1:0] data_d;

  always_comb begin
    data_d = data_q;
    unique case (bcast_i.op)
      plid_pkg::CELL_INS: begin
        if (MyIdx == bcast_i.pos_idx) begin
          data_d = bcast_i.ins_value;
        end else if (MyIdx > bcast_i.pos_idx) begin
          data_d = left_i;
        end
      end
      plid_pkg::CELL_DEL: begin
        if (MyIdx >= bcast_i.pos_idx) begin
          data_d = right_i;
        end
      end
      plid_pkg::CELL_ROT: begin
        if (MyIdx == bcast_i.tail_idx) begin
          data_d = bcast_i.head_value;
        end else if (MyIdx < bcast_i.tail_idx) begin
          data_d = right_i;
        end
      end
      default: data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign data_o = data_q;
  assign hit_o  = (MyIdx == bcast_i.pos_idx) ? data_q : '0;

endmodule

// File: design/positional_list_insert_delete.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_insert_delete
// Ordered list of up to CAPACITY signed values kept in a row of shift cells.
//
// Input channel (in_valid_i / in_stall_o) carries command, value, position;
// output channel (out_valid_o / out_stall_i) carries status, item_value,
// entry_count and last. A beat moves when valid is high and stall is low.
// Insert and delete shift the cells from the position onward in one step: an
// item is latched in the accept cycle and processed once the output register
// is free, and yields one result beat with last set. A readout of N entries
// streams N beats; the cell row rotates one place per beat, bringing the
// list back to order after the final beat, which carries last.
// A command is held in an input latch while the output register waits, so a
// stalled receiver freezes processing but not the accept of one item.
// Reset empties the list (count zero) and clears the output valid register;
// cell contents are not reset and are never read before written.
// ----------------------------------------------------------------------------
module positional_list_insert_delete #(
  parameter int unsigned CAPACITY = 16
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             command_i,
  input  logic signed [plid_pkg::DATA_W-1:0]     value_i,
  input  logic [plid_pkg::POS_W-1:0]             position_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [plid_pkg::STAT_W-1:0]            status_o,
  output logic signed [plid_pkg::DATA_W-1:0]     item_value_o,
  output logic [plid_pkg::CNT_OUT_W-1:0]         entry_count_o,
  output logic                                   last_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned PW = plid_pkg::POS_W + 1;

  plid_pkg::ctrl_state_e state_q, state_d;

  logic [CW-1:0] count_q, count_d;
  logic [CW-1:0] rd_cnt_q, rd_cnt_d;

  plid_pkg::cmd_e                      cmd_q;
  logic signed [plid_pkg::DATA_W-1:0]  val_q;
  logic [plid_pkg::POS_W-1:0]          pos_q;

  logic                                out_valid_q, out_valid_d;
  logic [plid_pkg::STAT_W-1:0]         out_status_q, out_status_d;
  logic signed [plid_pkg::DATA_W-1:0]  out_value_q, out_value_d;
  logic [CW-1:0]                       out_count_q, out_count_d;
  logic                                out_last_q, out_last_d;
  logic                                emit;

  plid_pkg::cell_bcast_t               bcast;
  logic signed [plid_pkg::DATA_W-1:0]  cell_data [CAPACITY];
  logic signed [plid_pkg::DATA_W-1:0]  cell_hit  [CAPACITY];
  logic signed [plid_pkg::DATA_W-1:0]  hit_value;

  logic          slot_free;
  logic          accept;
  logic [PW-1:0] pos_ext;
  logic [PW-1:0] cnt_ext;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic signed [plid_pkg::DATA_W-1:0] left_w;
    logic signed [plid_pkg::DATA_W-1:0] right_w;
    if (g == 0) begin : g_first
      assign left_w = cell_data[g];
    end else begin : g_mid_l
      assign left_w = cell_data[g-1];
    end
    if (g == CAPACITY - 1) begin : g_end
      assign right_w = cell_data[g];
    end else begin : g_mid_r
      assign right_w = cell_data[g+1];
    end
    plid_cell #(
      .IDX(g)
    ) u_cell (
      .clk_i  (clk_i),
      .bcast_i(bcast),
      .left_i (left_w),
      .right_i(right_w),
      .data_o (cell_data[g]),
      .hit_o  (cell_hit[g])
    );
  end

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      hit_value = hit_value | cell_hit[i];
    end
  end

  assign in_stall_o = (state_q != plid_pkg::CTRL_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;
  assign pos_ext    = PW'(pos_q);
  assign cnt_ext    = PW'(count_q);

  always_comb begin
    state_d            = state_q;
    count_d            = count_q;
    rd_cnt_d           = rd_cnt_q;
    emit               = 1'b0;
    out_status_d       = plid_pkg::ST_OK;
    out_value_d        = '0;
    out_count_d        = count_q;
    out_last_d         = 1'b1;
    bcast.op           = plid_pkg::CELL_HOLD;
    bcast.pos_idx      = plid_pkg::IDX_W'(pos_q) - plid_pkg::IDX_W'(1);
    bcast.tail_idx     = plid_pkg::IDX_W'(count_q) - plid_pkg::IDX_W'(1);
    bcast.ins_value    = val_q;
    bcast.head_value   = cell_data[0];

    unique case (state_q)
      plid_pkg::CTRL_IDLE: begin
        if (accept) begin
          state_d = plid_pkg::CTRL_HELD;
        end
      end
      plid_pkg::CTRL_HELD: begin
        if (slot_free) begin
          emit    = 1'b1;
          state_d = plid_pkg::CTRL_IDLE;
          unique case (cmd_q)
            plid_pkg::CMD_INSERT: begin
              if (pos_q == '0 || pos_ext > cnt_ext + PW'(1)) begin
                out_status_d = plid_pkg::ST_BADPOS;
              end else if (count_q == CW'(CAPACITY)) begin
                out_status_d = plid_pkg::ST_FULL;
              end else begin
                bcast.op    = plid_pkg::CELL_INS;
                count_d     = count_q + CW'(1);
                out_count_d = count_d;
              end
            end
            plid_pkg::CMD_DELETE: begin
              if (pos_q == '0 || pos_ext > cnt_ext) begin
                out_status_d = plid_pkg::ST_BADPOS;
              end else begin
                bcast.op    = plid_pkg::CELL_DEL;
                out_value_d = hit_value;
                count_d     = count_q - CW'(1);
                out_count_d = count_d;
              end
            end
            plid_pkg::CMD_READ: begin
              if (count_q == '0) begin
                out_status_d = plid_pkg::ST_EMPTY;
              end else begin
                bcast.op    = plid_pkg::CELL_ROT;
                out_value_d = cell_data[0];
                rd_cnt_d    = CW'(1);
                if (count_q != CW'(1)) begin
                  out_last_d = 1'b0;
                  state_d    = plid_pkg::CTRL_STREAM;
                end
              end
            end
            default: begin
              out_status_d = plid_pkg::ST_BADPOS;
            end
          endcase
        end
      end
      plid_pkg::CTRL_STREAM: begin
        if (slot_free) begin
          emit        = 1'b1;
          bcast.op    = plid_pkg::CELL_ROT;
          out_value_d = cell_data[0];
          rd_cnt_d    = rd_cnt_q + CW'(1);
          out_last_d  = (rd_cnt_d == count_q);
          if (out_last_d) begin
            state_d = plid_pkg::CTRL_IDLE;
          end
        end
      end
      default: state_d = plid_pkg::CTRL_IDLE;
    endcase

    if (emit) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= plid_pkg::CTRL_IDLE;
      count_q     <= '0;
      rd_cnt_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      rd_cnt_q    <= rd_cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= plid_pkg::cmd_e'(command_i);
      val_q <= value_i;
      pos_q <= position_i;
    end
    if (emit) begin
      out_status_q <= out_status_d;
      out_value_q  <= out_value_d;
      out_count_q  <= out_count_d;
      out_last_q   <= out_last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign item_value_o  = out_value_q;
  assign entry_count_o = plid_pkg::CNT_OUT_W'(out_count_q);
  assign last_o        = out_last_q;

endmodule
